FILE: hw/rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, skipped while reset is high
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked property, also checked during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/bpfx_pkg.sv
// shared types, operation codes and helpers of the bpf execute unit
package bpfx_pkg;

   localparam int unsigned XLEN = 64;
   localparam int unsigned HLEN = 32;

   localparam logic [4:0] MODE_MOV    = 5'd0;
   localparam logic [4:0] MODE_ADD    = 5'd1;
   localparam logic [4:0] MODE_SUB    = 5'd2;
   localparam logic [4:0] MODE_MUL    = 5'd3;
   localparam logic [4:0] MODE_OR     = 5'd4;
   localparam logic [4:0] MODE_AND    = 5'd5;
   localparam logic [4:0] MODE_XOR    = 5'd6;
   localparam logic [4:0] MODE_LSH    = 5'd7;
   localparam logic [4:0] MODE_RSH    = 5'd8;
   localparam logic [4:0] MODE_ARSH   = 5'd9;
   localparam logic [4:0] MODE_NEG    = 5'd10;
   localparam logic [4:0] MODE_UMULH  = 5'd11;
   localparam logic [4:0] MODE_SMULH  = 5'd12;
   localparam logic [4:0] MODE_UDIV   = 5'd13;
   localparam logic [4:0] MODE_UREM   = 5'd14;
   localparam logic [4:0] MODE_SDIV   = 5'd15;
   localparam logic [4:0] MODE_SREM   = 5'd16;
   localparam logic [4:0] MODE_TO_LE  = 5'd17;
   localparam logic [4:0] MODE_TO_BE  = 5'd18;
   localparam logic [4:0] MODE_HIOR   = 5'd19;
   localparam logic [4:0] MODE_JEQ    = 5'd20;
   localparam logic [4:0] MODE_JNE    = 5'd21;
   localparam logic [4:0] MODE_JUGT   = 5'd22;
   localparam logic [4:0] MODE_JUGE   = 5'd23;
   localparam logic [4:0] MODE_JULT   = 5'd24;
   localparam logic [4:0] MODE_JULE   = 5'd25;
   localparam logic [4:0] MODE_JSGT   = 5'd26;
   localparam logic [4:0] MODE_JSGE   = 5'd27;
   localparam logic [4:0] MODE_JSLT   = 5'd28;
   localparam logic [4:0] MODE_JSLE   = 5'd29;
   localparam logic [4:0] MODE_JSET   = 5'd30;

   localparam logic [1:0] FAULT_NONE   = 2'd0;
   localparam logic [1:0] FAULT_DIV0   = 2'd1;
   localparam logic [1:0] FAULT_OVFL   = 2'd2;
   localparam logic [1:0] FAULT_ENDIAN = 2'd3;

   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [4:0]        mode;
      logic              wide;
      logic [XLEN-1:0]   dest;
      logic [XLEN-1:0]   src;
      logic              swap;
      logic              sx;
   } item_type;

   typedef struct packed {
      logic run;
      logic done;
   } div_status_type;

   function automatic logic [XLEN-1:0] extend32(input logic [HLEN-1:0] v, input logic sx);
      extend32 = {{HLEN{sx & v[HLEN-1]}}, v};
   endfunction

   function automatic logic [XLEN-1:0] bswap(input logic [XLEN-1:0] v,
                                             input logic [3:0] nbytes);
      logic [XLEN-1:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nbytes) begin
            r[8*(int'(nbytes)-1-i) +: 8] = v[8*i +: 8];
         end
      end
      bswap = r;
   endfunction

endpackage

FILE: hw/rtl/bpf_alu_branch_execute_top.sv
// top level of the bpf alu and branch execute unit
//
//   channel | prefix | handshake     | payload
//   input   | req_   | valid / ready | mode, wide, dest, source, swap, sign extend
//   result  | rsp_   | valid / ready | result value, branch taken, fault
//
// alu, compare, endian and faulting items issue one per cycle when the output is free.
// mul, umulh and smulh run in the back end as partial products, sum, then correct.
// div and rem run on the divider, which yields one quotient bit per cycle.
// a two-entry queue between front and back lets new items enter while the back stalls.
// synchronous active-high reset empties the queue and the result register.
module bpf_alu_branch_execute_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_mode,
   input  logic        req_wide,
   input  logic [63:0] req_dest_value,
   input  logic [63:0] req_source_value,
   input  logic        req_swap_operands,
   input  logic        req_sign_extend_32,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_value,
   output logic        rsp_branch_taken,
   output logic [1:0]  rsp_fault
);

   logic               q_valid;
   logic               q_pop;
   bpfx_pkg::item_type q_item;

   bpfx_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_wide           (req_wide),
      .req_dest_value     (req_dest_value),
      .req_source_value   (req_source_value),
      .req_swap_operands  (req_swap_operands),
      .req_sign_extend_32 (req_sign_extend_32),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   bpfx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_fault        (rsp_fault)
   );

endmodule

FILE: hw/rtl/bpfx_front.sv
// front end: accepts items, classifies them and queues them for the back end
module bpfx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [4:0]            req_mode,
   input  logic                  req_wide,
   input  logic [63:0]           req_dest_value,
   input  logic [63:0]           req_source_value,
   input  logic                  req_swap_operands,
   input  logic                  req_sign_extend_32,
   output logic                  q_valid,
   output bpfx_pkg::item_type    q_item,
   input  logic                  q_pop
);

   bpfx_pkg::item_type entries_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   bpfx_pkg::item_type new_item;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      new_item.mode = req_mode;
      new_item.wide = req_wide;
      new_item.dest = req_dest_value;
      new_item.src  = req_source_value;
      new_item.swap = req_swap_operands;
      new_item.sx   = req_sign_extend_32;
      unique case (req_mode)
         bpfx_pkg::MODE_MUL, bpfx_pkg::MODE_UMULH, bpfx_pkg::MODE_SMULH:
            new_item.kind = bpfx_pkg::KIND_MUL;
         bpfx_pkg::MODE_UDIV, bpfx_pkg::MODE_UREM, bpfx_pkg::MODE_SDIV,
         bpfx_pkg::MODE_SREM:
            new_item.kind = bpfx_pkg::KIND_DIV;
         default:
            new_item.kind = bpfx_pkg::KIND_SIMPLE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: hw/rtl/bpfx_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module bpfx_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        ack,
   input  logic [63:0]                 dividend,
   input  logic [63:0]                 divisor,
   output bpfx_pkg::div_status_type    status,
   output logic [63:0]                 quotient,
   output logic [63:0]                 remainder
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;
   logic [65:0] diff;
   logic        ge;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge      = !diff[65];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[63:0] : shifted[63:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.run  = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

FILE: hw/rtl/bpfx_back.sv
// back end: executes queued items and holds the result register
module bpfx_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  bpfx_pkg::item_type    q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [63:0]           rsp_result_value,
   output logic                  rsp_branch_taken,
   output logic [1:0]            rsp_fault
);

   typedef enum logic [3:0] {
      ST_ISSUE = 4'b0001,
      ST_MSUM  = 4'b0010,
      ST_MOUT  = 4'b0100,
      ST_DIV   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   bpfx_pkg::item_type cur_ff, cur_in;
   logic [63:0]        pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [63:0]        prod_lo_ff, prod_hi_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        res_ff, res_in;
   logic               taken_ff, taken_in;
   logic [1:0]         fault_ff, fault_in;

   logic               out_free;
   logic               mul_take;

   // simple path on the queue head
   logic [63:0] d, s;
   logic [31:0] d32, s32;
   logic [63:0] v64;
   logic [31:0] v32;
   logic [63:0] simple_res;
   logic        simple_taken;
   logic [1:0]  simple_fault;
   logic [63:0] ca, cb, cfa, cfb, sgnbit;

   // divide setup on the queue head
   logic        h_signed, h_na, h_nb;
   logic [63:0] h_a, h_b, h_mask, h_ma, h_mb;
   logic        h_div0, h_ovfl;

   // divide finish on the held item
   logic        c_na, c_nb;
   logic [63:0] c_mask, div_res;
   logic        div_start, div_ack;
   bpfx_pkg::div_status_type div_st;
   logic [63:0] div_q, div_r;

   logic [64:0]  mid;
   logic [127:0] full;
   logic [63:0]  mul_res;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      d   = q_item.dest;
      s   = q_item.src;
      d32 = d[31:0];
      s32 = s[31:0];

      case (q_item.mode)
         bpfx_pkg::MODE_MOV:  v64 = s;
         bpfx_pkg::MODE_ADD:  v64 = d + s;
         bpfx_pkg::MODE_SUB:  v64 = q_item.swap ? s - d : d - s;
         bpfx_pkg::MODE_OR:   v64 = d | s;
         bpfx_pkg::MODE_AND:  v64 = d & s;
         bpfx_pkg::MODE_XOR:  v64 = d ^ s;
         bpfx_pkg::MODE_LSH:  v64 = d << s[5:0];
         bpfx_pkg::MODE_RSH:  v64 = d >> s[5:0];
         bpfx_pkg::MODE_ARSH: v64 = $unsigned($signed(d) >>> s[5:0]);
         default:             v64 = 64'd0 - d;
      endcase
      case (q_item.mode)
         bpfx_pkg::MODE_MOV:  v32 = s32;
         bpfx_pkg::MODE_ADD:  v32 = d32 + s32;
         bpfx_pkg::MODE_SUB:  v32 = q_item.swap ? s32 - d32 : d32 - s32;
         bpfx_pkg::MODE_OR:   v32 = d32 | s32;
         bpfx_pkg::MODE_AND:  v32 = d32 & s32;
         bpfx_pkg::MODE_XOR:  v32 = d32 ^ s32;
         bpfx_pkg::MODE_LSH:  v32 = d32 << s32[4:0];
         bpfx_pkg::MODE_RSH:  v32 = d32 >> s32[4:0];
         bpfx_pkg::MODE_ARSH: v32 = $unsigned($signed(d32) >>> s32[4:0]);
         default:             v32 = 32'd0 - d32;
      endcase

      // signed order by flipping the sign bit of the operand width
      ca     = q_item.wide ? d : {32'd0, d32};
      cb     = q_item.wide ? s : {32'd0, s32};
      sgnbit = q_item.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
      cfa    = ca ^ sgnbit;
      cfb    = cb ^ sgnbit;

      h_signed = (q_item.mode == bpfx_pkg::MODE_SDIV) ||
                 (q_item.mode == bpfx_pkg::MODE_SREM);
      h_mask   = q_item.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      h_a      = ca;
      h_b      = cb;
      h_na     = h_signed && ((h_a & sgnbit) != 64'd0);
      h_nb     = h_signed && ((h_b & sgnbit) != 64'd0);
      h_ma     = h_na ? ((64'd0 - h_a) & h_mask) : h_a;
      h_mb     = h_nb ? ((64'd0 - h_b) & h_mask) : h_b;
      h_div0   = (h_b == 64'd0);
      h_ovfl   = h_signed && (h_a == sgnbit) && (h_b == h_mask);

      simple_res   = d;
      simple_taken = 1'b0;
      simple_fault = bpfx_pkg::FAULT_NONE;
      case (q_item.mode)
         bpfx_pkg::MODE_MOV, bpfx_pkg::MODE_ADD, bpfx_pkg::MODE_SUB,
         bpfx_pkg::MODE_OR, bpfx_pkg::MODE_AND, bpfx_pkg::MODE_XOR,
         bpfx_pkg::MODE_LSH, bpfx_pkg::MODE_RSH, bpfx_pkg::MODE_ARSH,
         bpfx_pkg::MODE_NEG: begin
            simple_res = q_item.wide ? v64 : bpfx_pkg::extend32(v32, q_item.sx);
         end
         bpfx_pkg::MODE_UDIV, bpfx_pkg::MODE_UREM, bpfx_pkg::MODE_SDIV,
         bpfx_pkg::MODE_SREM: begin
            if (h_div0) begin
               simple_fault = bpfx_pkg::FAULT_DIV0;
            end else if (h_ovfl) begin
               simple_fault = bpfx_pkg::FAULT_OVFL;
            end
         end
         bpfx_pkg::MODE_TO_LE, bpfx_pkg::MODE_TO_BE: begin
            if (s == 64'd16) begin
               simple_res = (q_item.mode == bpfx_pkg::MODE_TO_BE) ?
                            bpfx_pkg::bswap(d, 4'd2) : {48'd0, d[15:0]};
            end else if (s == 64'd32) begin
               simple_res = (q_item.mode == bpfx_pkg::MODE_TO_BE) ?
                            bpfx_pkg::bswap(d, 4'd4) : {32'd0, d32};
            end else if (s == 64'd64) begin
               simple_res = (q_item.mode == bpfx_pkg::MODE_TO_BE) ?
                            bpfx_pkg::bswap(d, 4'd8) : d;
            end else begin
               simple_fault = bpfx_pkg::FAULT_ENDIAN;
            end
         end
         bpfx_pkg::MODE_HIOR: simple_res = d | {s32, 32'd0};
         bpfx_pkg::MODE_JEQ:  simple_taken = (ca == cb);
         bpfx_pkg::MODE_JNE:  simple_taken = (ca != cb);
         bpfx_pkg::MODE_JUGT: simple_taken = (ca > cb);
         bpfx_pkg::MODE_JUGE: simple_taken = (ca >= cb);
         bpfx_pkg::MODE_JULT: simple_taken = (ca < cb);
         bpfx_pkg::MODE_JULE: simple_taken = (ca <= cb);
         bpfx_pkg::MODE_JSGT: simple_taken = (cfa > cfb);
         bpfx_pkg::MODE_JSGE: simple_taken = (cfa >= cfb);
         bpfx_pkg::MODE_JSLT: simple_taken = (cfa < cfb);
         bpfx_pkg::MODE_JSLE: simple_taken = (cfa <= cfb);
         bpfx_pkg::MODE_JSET: simple_taken = ((ca & cb) != 64'd0);
         default: ;
      endcase
   end

   // multiply: partial products at issue, sum, then select and correct
   always_comb begin
      mid  = {1'b0, pp_hl_ff} + {1'b0, pp_lh_ff};
      full = {pp_hh_ff, pp_ll_ff} + {31'd0, mid, 32'd0};
   end

   always_comb begin
      case (cur_ff.mode)
         bpfx_pkg::MODE_UMULH: mul_res = prod_hi_ff;
         bpfx_pkg::MODE_SMULH:
            mul_res = prod_hi_ff - (cur_ff.dest[63] ? cur_ff.src : 64'd0)
                                 - (cur_ff.src[63] ? cur_ff.dest : 64'd0);
         default:
            mul_res = cur_ff.wide ? prod_lo_ff
                                  : bpfx_pkg::extend32(prod_lo_ff[31:0], cur_ff.sx);
      endcase
   end

   // divide sign fix on the held item; 32-bit results stay zero-extended
   always_comb begin
      c_mask = cur_ff.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      c_na   = ((cur_ff.mode == bpfx_pkg::MODE_SDIV) || (cur_ff.mode == bpfx_pkg::MODE_SREM))
               && (cur_ff.wide ? cur_ff.dest[63] : cur_ff.dest[31]);
      c_nb   = ((cur_ff.mode == bpfx_pkg::MODE_SDIV) || (cur_ff.mode == bpfx_pkg::MODE_SREM))
               && (cur_ff.wide ? cur_ff.src[63] : cur_ff.src[31]);
      if ((cur_ff.mode == bpfx_pkg::MODE_UREM) || (cur_ff.mode == bpfx_pkg::MODE_SREM)) begin
         div_res = (c_na ? (64'd0 - div_r) : div_r) & c_mask;
      end else begin
         div_res = ((c_na != c_nb) ? (64'd0 - div_q) : div_q) & c_mask;
      end
   end

   bpfx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .ack       (div_ack),
      .dividend  (h_ma),
      .divisor   (h_mb),
      .status    (div_st),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_ack      = 1'b0;
      mul_take     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      res_in       = res_ff;
      taken_in     = taken_ff;
      fault_in     = fault_ff;
      unique case (state_ff)
         ST_ISSUE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (q_item.kind == bpfx_pkg::KIND_MUL) begin
                  mul_take = 1'b1;
                  state_in = ST_MSUM;
               end else if ((q_item.kind == bpfx_pkg::KIND_DIV) && !h_div0 && !h_ovfl) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  rsp_valid_in = 1'b1;
                  res_in       = simple_res;
                  taken_in     = simple_taken;
                  fault_in     = simple_fault;
               end
            end
         end
         ST_MSUM: state_in = ST_MOUT;
         ST_MOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               res_in       = mul_res;
               taken_in     = 1'b0;
               fault_in     = bpfx_pkg::FAULT_NONE;
               state_in     = ST_ISSUE;
            end
         end
         ST_DIV: begin
            if (div_st.done && out_free) begin
               div_ack      = 1'b1;
               rsp_valid_in = 1'b1;
               res_in       = div_res;
               taken_in     = 1'b0;
               fault_in     = bpfx_pkg::FAULT_NONE;
               state_in     = ST_ISSUE;
            end
         end
         default: state_in = ST_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      res_ff   <= res_in;
      taken_ff <= taken_in;
      fault_ff <= fault_in;
      if (mul_take) begin
         pp_ll_ff <= {32'd0, q_item.dest[31:0]}  * {32'd0, q_item.src[31:0]};
         pp_lh_ff <= {32'd0, q_item.dest[31:0]}  * {32'd0, q_item.src[63:32]};
         pp_hl_ff <= {32'd0, q_item.dest[63:32]} * {32'd0, q_item.src[31:0]};
         pp_hh_ff <= {32'd0, q_item.dest[63:32]} * {32'd0, q_item.src[63:32]};
      end
      if (state_ff == ST_MSUM) begin
         prod_lo_ff <= full[63:0];
         prod_hi_ff <= full[127:64];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_branch_taken = taken_ff;
   assign rsp_fault        = fault_ff;

endmodule

FILE: hw/rtl/bpfx_checker.sv
// port-level checks of the execute unit, bound to the top level
`include "assert_macros.svh"

module bpfx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result_value,
   input logic        rsp_branch_taken,
   input logic [1:0]  rsp_fault
);

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `CHK_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_result_value))
   `CHK_ASSERT(a_fault_no_branch, clock, reset, rsp_valid && (rsp_fault != bpfx_pkg::FAULT_NONE) |-> !rsp_branch_taken)
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

bind bpf_alu_branch_execute_top bpfx_checker u_bpfx_checker (.*);

FILE: test/bpf_alu_branch_execute_top_tb.sv
// self-checking testbench for the bpf alu and branch execute unit
module bpf_alu_branch_execute_top_tb;
   import bpfx_pkg::*;

   // mode code with no operation behind it
   localparam logic [4:0] MODE_UNUSED = 5'd31;

   typedef struct {
      logic [4:0]  mode;
      logic        wide;
      logic [63:0] dest;
      logic [63:0] src;
      logic        swap;
      logic        sx;
   } exec_op_type;

   typedef struct {
      logic [63:0] value;
      logic        taken;
      logic [1:0]  fault;
   } exec_res_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [4:0]  req_mode = '0;
   logic        req_wide = 0;
   logic [63:0] req_dest_value = '0;
   logic [63:0] req_source_value = '0;
   logic        req_swap_operands = 0;
   logic        req_sign_extend_32 = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_result_value;
   logic        rsp_branch_taken;
   logic [1:0]  rsp_fault;

   bpf_alu_branch_execute_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   exec_op_type  pending_ops[$];
   exec_res_type expected_res[$];
   int        errors = 0;
   bit        stim_done = 0;
   int        cycle_count = 0;
   int        hold_cycles = 0;
   int        send_gap = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(3);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [63:0] sext32(logic [31:0] v, logic sx);
      return sx ? {{32{v[31]}}, v} : {32'd0, v};
   endfunction

   function automatic logic [63:0] byte_rev(logic [63:0] v, int n);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < n; i++) r[8*(n-1-i) +: 8] = v[8*i +: 8];
      return r;
   endfunction

   // behavioral model of one executed operation
   function automatic exec_res_type execute_op(exec_op_type op);
      exec_res_type r;
      logic [31:0] d32, s32, v;
      logic [63:0] a, b, mask, sb;
      logic [127:0] prod;
      r.value = op.dest; r.taken = 0; r.fault = FAULT_NONE;
      d32 = op.dest[31:0]; s32 = op.src[31:0];
      a = op.wide ? op.dest : {32'd0, d32};
      b = op.wide ? op.src : {32'd0, s32};
      mask = op.wide ? '1 : 64'hFFFF_FFFF;
      sb = op.wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
      if (op.mode <= MODE_NEG) begin
         if (op.wide) begin
            case (op.mode)
               MODE_MOV:  r.value = op.src;
               MODE_ADD:  r.value = op.dest + op.src;
               MODE_SUB:  r.value = op.swap ? op.src - op.dest : op.dest - op.src;
               MODE_MUL:  r.value = op.dest * op.src;
               MODE_OR:   r.value = op.dest | op.src;
               MODE_AND:  r.value = op.dest & op.src;
               MODE_XOR:  r.value = op.dest ^ op.src;
               MODE_LSH:  r.value = op.dest << op.src[5:0];
               MODE_RSH:  r.value = op.dest >> op.src[5:0];
               MODE_ARSH: r.value = $signed(op.dest) >>> op.src[5:0];
               default:   r.value = -op.dest;
            endcase
         end else begin
            case (op.mode)
               MODE_MOV:  v = s32;
               MODE_ADD:  v = d32 + s32;
               MODE_SUB:  v = op.swap ? s32 - d32 : d32 - s32;
               MODE_MUL:  v = d32 * s32;
               MODE_OR:   v = d32 | s32;
               MODE_AND:  v = d32 & s32;
               MODE_XOR:  v = d32 ^ s32;
               MODE_LSH:  v = d32 << s32[4:0];
               MODE_RSH:  v = d32 >> s32[4:0];
               MODE_ARSH: v = $signed(d32) >>> s32[4:0];
               default:   v = -d32;
            endcase
            r.value = sext32(v, op.sx);
         end
      end else if (op.mode == MODE_UMULH) begin
         prod = {64'd0, op.dest} * {64'd0, op.src};
         r.value = prod[127:64];
      end else if (op.mode == MODE_SMULH) begin
         prod = $signed({{64{op.dest[63]}}, op.dest}) * $signed({{64{op.src[63]}}, op.src});
         r.value = prod[127:64];
      end else if (op.mode <= MODE_SREM) begin
         if (b == 0) r.fault = FAULT_DIV0;
         else if (op.mode >= MODE_SDIV && a == sb && b == mask) r.fault = FAULT_OVFL;
         else if (op.mode == MODE_UDIV) r.value = a / b;
         else if (op.mode == MODE_UREM) r.value = a % b;
         else begin
            logic [63:0] ma, mb, q, rm;
            ma = (a & sb) != 0 ? (-a) & mask : a;
            mb = (b & sb) != 0 ? (-b) & mask : b;
            q = ma / mb; rm = ma % mb;
            if (op.mode == MODE_SREM) r.value = ((a & sb) != 0 ? -rm : rm) & mask;
            else r.value = (((a & sb) != 0) != ((b & sb) != 0) ? -q : q) & mask;
         end
      end else if (op.mode <= MODE_TO_BE) begin
         case (op.src)
            64'd16: r.value = op.mode == MODE_TO_BE ? byte_rev(op.dest, 2) : op.dest & 64'hFFFF;
            64'd32: r.value = op.mode == MODE_TO_BE ? byte_rev(op.dest, 4)
                                                    : op.dest & 64'hFFFF_FFFF;
            64'd64: r.value = op.mode == MODE_TO_BE ? byte_rev(op.dest, 8) : op.dest;
            default: r.fault = FAULT_ENDIAN;
         endcase
      end else if (op.mode == MODE_HIOR) begin
         r.value = op.dest | {s32, 32'd0};
      end else if (op.mode <= MODE_JSET) begin
         case (op.mode)
            MODE_JEQ:  r.taken = a == b;
            MODE_JNE:  r.taken = a != b;
            MODE_JUGT: r.taken = a > b;
            MODE_JUGE: r.taken = a >= b;
            MODE_JULT: r.taken = a < b;
            MODE_JULE: r.taken = a <= b;
            MODE_JSGT: r.taken = (a ^ sb) > (b ^ sb);
            MODE_JSGE: r.taken = (a ^ sb) >= (b ^ sb);
            MODE_JSLT: r.taken = (a ^ sb) < (b ^ sb);
            MODE_JSLE: r.taken = (a ^ sb) <= (b ^ sb);
            default:   r.taken = (a & b) != 0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // operands biased toward edge values
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h0000_0000_8000_0000;
         4: return 64'h0000_0000_FFFF_FFFF;
         5: return 64'($urandom_range(70));
         6: return {32'd0, $urandom};
         default: return rand64();
      endcase
   endfunction

   task automatic add_op(logic [4:0] m, logic w, logic [63:0] d, logic [63:0] s,
                         logic sw, logic sx);
      exec_op_type op;
      op.mode = m; op.wide = w; op.dest = d; op.src = s; op.swap = sw; op.sx = sx;
      pending_ops = {pending_ops, op};
   endtask

   initial begin
      exec_op_type op;
      // directed corners
      add_op(MODE_SUB, 1'b1, 64'd5, 64'd9, 1'b1, 1'b0);
      add_op(MODE_SUB, 1'b0, 64'd5, 64'd9, 1'b0, 1'b1);
      add_op(MODE_MOV, 1'b0, '1, 64'h8000_0000, 1'b0, 1'b1);
      add_op(MODE_LSH, 1'b1, 64'd1, 64'd67, 1'b0, 1'b0);
      add_op(MODE_ARSH, 1'b0, 64'h8000_0000, 64'd33, 1'b0, 1'b1);
      add_op(MODE_NEG, 1'b0, 64'd1, '1, 1'b0, 1'b0);
      add_op(MODE_UMULH, 1'b0, '1, '1, 1'b0, 1'b0);
      add_op(MODE_SMULH, 1'b1, 64'h8000_0000_0000_0000, '1, 1'b0, 1'b0);
      add_op(MODE_UDIV, 1'b1, 64'd7, 64'd0, 1'b0, 1'b0);
      add_op(MODE_SDIV, 1'b1, 64'h8000_0000_0000_0000, '1, 1'b0, 1'b0);
      add_op(MODE_SREM, 1'b0, 64'h8000_0000, 64'hFFFF_FFFF, 1'b0, 1'b0);
      add_op(MODE_SDIV, 1'b0, 64'hFFFF_FFF9, 64'd2, 1'b0, 1'b1);
      add_op(MODE_SREM, 1'b1, -64'sd7, 64'd2, 1'b0, 1'b0);
      add_op(MODE_UREM, 1'b0, 64'h1_0000_0005, 64'h1_0000_0000, 1'b0, 1'b0);
      add_op(MODE_TO_LE, 1'b0, 64'h0123_4567_89AB_CDEF, 64'd16, 1'b0, 1'b0);
      add_op(MODE_TO_BE, 1'b1, 64'h0123_4567_89AB_CDEF, 64'd32, 1'b0, 1'b0);
      add_op(MODE_TO_BE, 1'b0, 64'h0123_4567_89AB_CDEF, 64'd64, 1'b0, 1'b0);
      add_op(MODE_TO_LE, 1'b0, 64'd1, 64'd8, 1'b0, 1'b0);
      add_op(MODE_HIOR, 1'b0, 64'd3, '1, 1'b0, 1'b0);
      add_op(MODE_JSGT, 1'b0, 64'h7FFF_FFFF, 64'h8000_0000, 1'b0, 1'b0);
      add_op(MODE_JSET, 1'b1, 64'h8000_0000_0000_0000, '1, 1'b0, 1'b0);
      add_op(MODE_UNUSED, 1'b1, 64'd42, 64'd1, 1'b1, 1'b1);
      for (int i = 0; i < 1030; i++) begin
         op.mode = 5'($urandom_range(31));
         // keep slow divides to a modest share
         if (op.mode >= MODE_UDIV && op.mode <= MODE_SREM && $urandom_range(2) != 0)
            op.mode = 5'($urandom_range(12));
         op.wide = 1'($urandom_range(1));
         op.dest = pick_operand();
         op.src = pick_operand();
         if ((op.mode == MODE_TO_LE || op.mode == MODE_TO_BE) && $urandom_range(3) != 0)
            op.src = 64'd16 << $urandom_range(2);
         op.swap = 1'($urandom_range(1));
         op.sx = 1'($urandom_range(1));
         pending_ops = {pending_ops, op};
      end
      repeat (3) @(posedge clock);
      reset <= 0;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_res = {expected_res, execute_op(pending_ops.pop_front())};
            send_gap = pick_gap();
         end
         if (req_valid && !req_ready) begin
            // hold payload
         end else if (send_gap > 0 || pending_ops.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_valid <= 0;
            if (pending_ops.size() == 0 && !(req_valid && !req_ready)) stim_done = 1;
         end else begin
            req_valid <= 1;
            req_mode <= pending_ops[0].mode;
            req_wide <= pending_ops[0].wide;
            req_dest_value <= pending_ops[0].dest;
            req_source_value <= pending_ops[0].src;
            req_swap_operands <= pending_ops[0].swap;
            req_sign_extend_32 <= pending_ops[0].sx;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      exec_res_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_res.size() == 0) begin
               $error("unexpected item: value %h", rsp_result_value);
               errors++;
            end else begin
               e = expected_res.pop_front();
               if (rsp_result_value !== e.value) begin
                  $error("result_value expected %h actual %h", e.value, rsp_result_value);
                  errors++;
               end
               if (rsp_branch_taken !== e.taken) begin
                  $error("branch_taken expected %b actual %b", e.taken, rsp_branch_taken);
                  errors++;
               end
               if (rsp_fault !== e.fault) begin
                  $error("fault expected %0d actual %0d", e.fault, rsp_fault);
                  errors++;
               end
            end
         end
         if (cycle_count == 200) hold_cycles = 300;   // long back-pressure stretch
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 0;
         end else if ((cycle_count / 2000) % 2 == 1) begin
            rsp_ready <= 1;
         end else begin
            hold_cycles = pick_gap();
            rsp_ready <= hold_cycles == 0;
         end
      end
   end

   initial begin
      int tail;
      tail = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (stim_done && !req_valid && expected_res.size() == 0) tail++;
         else tail = 0;
         if (tail > 100) begin
            if (errors == 0) $display("SCOREBOARD CLEAN");
            else $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule
